>>> rtl/i2c_master_bit_engine_core_assert.svh
// assertion macros shared by the i2c master bit engine rtl
// expects a clock named clock and a synchronous active-high reset named reset
`ifndef I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define I2CMBE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cmbe assertion failed");

// next-cycle implication, checked outside reset
`define I2CMBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cmbe assertion failed");

`endif

>>> rtl/i2cmbe_pkg.sv
// shared types, command codes and unit sequencing functions for the i2c bit engine
// no dependencies
`default_nettype none

package i2cmbe_pkg;

   // widths
   localparam int CFG_W     = 16;
   localparam int DIV_WIDTH = 16;
   localparam int OP_W      = 3;
   localparam int PHASE_W   = 5;
   localparam int REQ_W     = 16;
   localparam int RSP_W     = 16;

   localparam logic [32:0] DIV_LIM = 33'((64'd1 << DIV_WIDTH) - 64'd1);

   localparam logic [CFG_W-1:0] DELAY_RST = CFG_W'(4);

   // command codes (S and P are the bus open/close conditions)
   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_SCOND = 3'd1;
   localparam logic [OP_W-1:0] OP_PCOND = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ  = 3'd4;

   // phase codes: idle, else unit index + 1
   localparam logic [PHASE_W-1:0] PHASE_IDLE = 5'd0;
   localparam logic [PHASE_W-1:0] UNIT_FIRST = 5'd0;
   localparam logic [PHASE_W-1:0] UNIT_BITS  = 5'd16;
   localparam logic [PHASE_W-1:0] UNIT_ACK0  = 5'd16;
   localparam logic [PHASE_W-1:0] UNIT_ACK1  = 5'd17;
   localparam logic [PHASE_W-1:0] UNIT_ACK2  = 5'd18;

   typedef struct packed {
      logic scl;
      logic sda;
      logic oe;
   } pins_type;

   localparam pins_type PINS_RST = '{scl: 1'b0, sda: 1'b1, oe: 1'b1};

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [7:0]      wdata;
      logic            send_nack;
      logic            sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_level;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rdata;
      logic       ack_seen;
   } rsp_type;

   // number of units in a command
   function automatic logic [PHASE_W-1:0] unit_total(input logic [OP_W-1:0] kind);
      logic [PHASE_W-1:0] n;
      if (kind == OP_WRITE)     n = UNIT_BITS + 5'd3;
      else if (kind == OP_READ) n = UNIT_BITS + 5'd4;
      else                      n = 5'd5;
      return n;
   endfunction

   // reload value for the unit timer: zero acts as one, clamp to counter range
   function automatic logic [DIV_WIDTH-1:0] load_value(input logic [CFG_W-1:0] dt);
      logic [32:0] v;
      v = 33'(dt);
      if (v == 33'd0) v = 33'd1;
      if (v > DIV_LIM) v = DIV_LIM;
      return v[DIV_WIDTH-1:0];
   endfunction

   // pin changes on entering unit u
   function automatic pins_type enter_unit(input logic [OP_W-1:0]    kind,
                                           input logic [PHASE_W-1:0] u,
                                           input logic [7:0]         shift,
                                           input logic               nack,
                                           input pins_type           cur);
      pins_type p;
      p = cur;
      if (kind == OP_SCOND) begin
         if (u == 5'd0)      p.oe  = 1'b1;
         else if (u == 5'd1) p.sda = 1'b1;
         else if (u == 5'd2) p.scl = 1'b1;
         else if (u == 5'd3) p.sda = 1'b0;
         else                p.scl = 1'b0;
      end else if (kind == OP_PCOND) begin
         if (u == 5'd0)      p.oe  = 1'b1;
         else if (u == 5'd1) p.sda = 1'b0;
         else if (u == 5'd2) p.scl = 1'b1;
         else if (u == 5'd3) p.sda = 1'b1;
      end else if (u < UNIT_BITS) begin
         if (u[0]) begin
            p.scl = 1'b1;
         end else begin
            if (u != UNIT_FIRST) p.scl = 1'b0;
            if (kind == OP_WRITE) begin
               p.oe  = 1'b1;
               p.sda = shift[~u[3:1]];
            end
         end
      end else if (u == UNIT_ACK0) begin
         p.scl = 1'b0;
         p.oe  = (kind == OP_READ);
      end else if (u == UNIT_ACK1) begin
         if (kind == OP_READ) p.sda = nack;
         else                 p.scl = 1'b1;
      end else if (u == UNIT_ACK2) begin
         p.scl = (kind == OP_READ);
      end else begin
         p.scl = 1'b0;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/i2cmbe_seq.sv
// unit sequencer: state registers and the per-tick next-state logic
// depends on i2cmbe_pkg and the assertion macro header
`default_nettype none
`include "i2c_master_bit_engine_core_assert.svh"

module i2cmbe_seq
   import i2cmbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire req_type          req_i,
   input  wire logic [CFG_W-1:0] delay_ticks_i,
   output rsp_type               rsp_o
);

   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [7:0]           shift_ff, shift_in;
   logic [DIV_WIDTH-1:0] cnt_ff, cnt_in;
   logic [OP_W-1:0]      kind_ff, kind_in;
   logic                 nack_ff, nack_in;
   pins_type             pins_ff, pins_in;
   logic                 ack_ff, ack_in;
   logic [7:0]           rdata_ff, rdata_in;
   logic                 done_in;
   logic [DIV_WIDTH-1:0] cnt_dec;
   logic [PHASE_W-1:0]   u_cur;
   logic [7:0]           shift_new;
   pins_type             pins_acc;
   logic                 cmd_ok;

   assign u_cur   = phase_ff - 5'd1;
   assign cnt_dec = (cnt_ff != '0) ? cnt_ff - DIV_WIDTH'(1) : '0;
   assign cmd_ok  = (req_i.op >= OP_SCOND) && (req_i.op <= OP_READ);

   // command accept values
   always_comb begin
      shift_new = (req_i.op == OP_WRITE) ? req_i.wdata : 8'd0;
      pins_acc  = pins_ff;
      if (req_i.op == OP_READ) begin
         pins_acc.oe  = 1'b0;
         pins_acc.sda = 1'b1;
      end
   end

   // next state for one tick
   always_comb begin
      phase_in = phase_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      nack_in  = nack_ff;
      pins_in  = pins_ff;
      ack_in   = ack_ff;
      rdata_in = rdata_ff;
      done_in  = 1'b0;
      if (phase_ff == PHASE_IDLE) begin
         if (cmd_ok) begin
            kind_in  = req_i.op;
            nack_in  = req_i.send_nack;
            shift_in = shift_new;
            phase_in = 5'd1;
            cnt_in   = load_value(delay_ticks_i);
            pins_in  = enter_unit(req_i.op, UNIT_FIRST, shift_new, req_i.send_nack,
                                  pins_acc);
         end
      end else begin
         cnt_in = cnt_dec;
         if (cnt_dec == '0) begin
            // sample on the last tick of the unit
            if (kind_ff == OP_READ && u_cur < UNIT_BITS && !u_cur[0])
               shift_in[~u_cur[3:1]] = shift_ff[~u_cur[3:1]] | req_i.sda_in;
            else if (kind_ff == OP_WRITE && u_cur == UNIT_ACK1)
               ack_in = req_i.sda_in;
            if (phase_ff >= unit_total(kind_ff)) begin
               if (kind_ff == OP_READ) rdata_in = shift_in;
               phase_in = PHASE_IDLE;
               done_in  = 1'b1;
            end else begin
               phase_in = phase_ff + 5'd1;
               cnt_in   = load_value(delay_ticks_i);
               pins_in  = enter_unit(kind_ff, phase_ff, shift_in, nack_ff, pins_ff);
            end
         end
      end
   end

   // state registers, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         shift_ff <= '0;
         cnt_ff   <= '0;
         kind_ff  <= OP_NONE;
         nack_ff  <= 1'b0;
         pins_ff  <= PINS_RST;
         ack_ff   <= 1'b0;
         rdata_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_in;
         kind_ff  <= kind_in;
         nack_ff  <= nack_in;
         pins_ff  <= pins_in;
         ack_ff   <= ack_in;
         rdata_ff <= rdata_in;
      end
   end

   // result of this tick, after the update
   always_comb begin
      rsp_o.scl       = pins_in.scl;
      rsp_o.sda_level = pins_in.sda;
      rsp_o.sda_oe    = pins_in.oe;
      rsp_o.busy_res  = (phase_in != PHASE_IDLE);
      rsp_o.done_res  = done_in;
      rsp_o.rdata     = rdata_in;
      rsp_o.ack_seen  = ack_in;
   end

   // a busy sequencer always has time left in its unit
   `I2CMBE_ASSERT_NOW(a_busy_cnt, phase_ff != PHASE_IDLE, cnt_ff != '0)
   // phase never runs past the end of the command
   `I2CMBE_ASSERT_NOW(a_phase_rng, phase_ff != PHASE_IDLE, phase_ff <= unit_total(kind_ff))
   // sda stays released while read data bits are clocked in
   `I2CMBE_ASSERT_NOW(a_read_rel, phase_ff != PHASE_IDLE && kind_ff == OP_READ &&
                      phase_ff <= UNIT_BITS, !pins_ff.oe)
   // without a tick the sequencer does not move
   `I2CMBE_ASSERT_NEXT(a_hold, !step_en, $stable(phase_ff) && $stable(cnt_ff))

endmodule

`default_nettype wire

>>> rtl/i2c_master_bit_engine_core.sv
// i2c master bit engine top: input beat register, unit sequencer, result register
// depends on i2cmbe_pkg, i2cmbe_seq and the assertion macro header
//
//  channel   dir  handshake               payload
//  req       in   req_tvalid/req_tready   req_tdata[9:0], req_tuser[2:0] (op)
//  rsp       out  rsp_tvalid/rsp_tready   rsp_tdata[13:0]
//  csr       in   csr_valid/csr_ready     csr_data[15:0] (delay_ticks)
//
// one beat per cycle sustained while rsp_tready stays high; each req beat is one
// tick and yields one rsp beat; a beat is held in the input register, then one
// tick step updates the sequencer state and loads the result register
// reset is synchronous: pins go to scl 0, sda 1, oe 1, delay_ticks to 4
// a stalled rsp holds the result register; req keeps flowing until the input
// register is also full, then req_tready drops
`default_nettype none
`include "i2c_master_bit_engine_core_assert.svh"

module i2c_master_bit_engine_core
   import i2cmbe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // req_tdata: wdata[7:0], send_nack[8], sda_in[9], zero fill
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,
   // req_tuser: op[2:0]
   input  wire logic [OP_W-1:0]   req_tuser,
   // rsp_tdata: scl[0], sda_level[1], sda_oe[2], busy_res[3], done_res[4],
   //            rdata[12:5], ack_seen[13], zero fill
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CFG_W-1:0]  csr_data
);

   logic             in_vld_ff, in_vld_in;
   req_type          in_req_ff;
   logic             out_vld_ff, out_vld_in;
   rsp_type          out_rsp_ff;
   rsp_type          step_rsp;
   logic [CFG_W-1:0] delay_ff;
   logic             advance;

   // a tick steps when it is held and the result register has room
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);
   assign csr_ready  = 1'b1;

   // delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         delay_ff <= csr_data;
      end
   end

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff.op        <= req_tuser;
         in_req_ff.wdata     <= req_tdata[7:0];
         in_req_ff.send_nack <= req_tdata[8];
         in_req_ff.sda_in    <= req_tdata[9];
      end
   end

   i2cmbe_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .req_i         (in_req_ff),
      .delay_ticks_i (delay_ff),
      .rsp_o         (step_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= step_rsp;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, out_rsp_ff.ack_seen, out_rsp_ff.rdata, out_rsp_ff.done_res,
                        out_rsp_ff.busy_res, out_rsp_ff.sda_oe, out_rsp_ff.sda_level,
                        out_rsp_ff.scl};

   // a held tick that cannot step stays held
   `I2CMBE_ASSERT_NEXT(a_in_keep, in_vld_ff && !advance, in_vld_ff)
   // a stepped tick always lands in the result register
   `I2CMBE_ASSERT_NEXT(a_out_load, advance, out_vld_ff)
   // a result never stepped over while stalled
   `I2CMBE_ASSERT_NOW(a_no_overrun, out_vld_ff && !rsp_tready, !advance)

endmodule

`default_nettype wire

>>> dv/i2c_master_bit_engine_core_tb.sv
// self-checking testbench for the i2c master bit engine core
// depends on i2cmbe_pkg and the i2c_master_bit_engine_core rtl; a local pin
// sequencer model predicts every rsp beat from the accepted req beats
`default_nettype none

module i2c_master_bit_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import i2cmbe_pkg::*;

   localparam int CLK_PERIOD = 10;
   localparam int RESET_CYCLES = 9;
   localparam int LONG_HOLD = 80;
   localparam int SEG_BEATS = 160;
   localparam int SEG_COUNT = 5;

   // op codes outside the command set, taken as no command
   localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   // pins and flags of an idle engine straight after reset
   localparam rsp_type RSP_AT_RESET = '{scl: 1'b0, sda_level: 1'b1, sda_oe: 1'b1,
                                        busy_res: 1'b0, done_res: 1'b0,
                                        rdata: 8'h00, ack_seen: 1'b0};
   // first tick of a bus open condition from reset: only busy rises
   localparam rsp_type RSP_SCOND_ENTRY = '{scl: 1'b0, sda_level: 1'b1, sda_oe: 1'b1,
                                           busy_res: 1'b1, done_res: 1'b0,
                                           rdata: 8'h00, ack_seen: 1'b0};

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      req_type          beat;
      logic [31:0]      reps;
      logic [CFG_W-1:0] csr_value;
      logic             typed;
      rsp_type          known;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]  req_tuser = OP_NONE;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   // run control shared by the sender and receiver sides
   bit quiet = 1'b0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int fail_count = 0;

   stim_row_type dir_rows [$];
   rsp_type      predicted_rsp_q [$];

   // sequencer model state
   logic [PHASE_W-1:0]   eng_phase;
   logic [DIV_WIDTH-1:0] eng_count;
   logic [OP_W-1:0]      eng_kind;
   logic [7:0]           eng_shift;
   logic                 eng_nack;
   logic                 eng_ack;
   logic [7:0]           eng_rdata;
   logic                 pin_scl;
   logic                 pin_sda;
   logic                 pin_oe;
   logic [CFG_W-1:0]     delay_cfg;

   i2c_master_bit_engine_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // pin changes on entering unit u, and the unit timer reload
   task automatic enter_pin_unit(input logic [PHASE_W-1:0] u);
      // a zero delay counts as one; 16 bits never exceed the counter range
      eng_count = (delay_cfg == '0) ? DIV_WIDTH'(1) : DIV_WIDTH'(delay_cfg);
      if (eng_kind == OP_SCOND) begin
         if (u == 5'd0)      pin_oe  = 1'b1;
         else if (u == 5'd1) pin_sda = 1'b1;
         else if (u == 5'd2) pin_scl = 1'b1;
         else if (u == 5'd3) pin_sda = 1'b0;
         else                pin_scl = 1'b0;
      end else if (eng_kind == OP_PCOND) begin
         if (u == 5'd0)      pin_oe  = 1'b1;
         else if (u == 5'd1) pin_sda = 1'b0;
         else if (u == 5'd2) pin_scl = 1'b1;
         else if (u == 5'd3) pin_sda = 1'b1;
      end else if (u < UNIT_BITS) begin
         // data bits: even unit holds scl low and, on a write, sets up sda; odd unit raises scl
         if (u[0]) begin
            pin_scl = 1'b1;
         end else begin
            if (u != UNIT_FIRST) pin_scl = 1'b0;
            if (eng_kind == OP_WRITE) begin
               pin_oe  = 1'b1;
               pin_sda = eng_shift[3'd7 - u[3:1]];
            end
         end
      end else if (u == UNIT_ACK0) begin
         pin_scl = 1'b0;
         pin_oe  = (eng_kind == OP_READ);
      end else if (u == UNIT_ACK1) begin
         if (eng_kind == OP_READ) pin_sda = eng_nack;
         else                     pin_scl = 1'b1;
      end else if (u == UNIT_ACK2) begin
         pin_scl = (eng_kind == OP_READ);
      end else begin
         pin_scl = 1'b0;
      end
   endtask

   // one tick of the pin sequencer: returns the rsp beat it produces
   task automatic advance_sequencer(input req_type b, output rsp_type o);
      logic               done;
      logic [PHASE_W-1:0] u;
      logic [PHASE_W-1:0] n_units;
      done = 1'b0;
      if (eng_phase == PHASE_IDLE) begin
         // commands are only taken on a tick that starts idle
         if (b.op >= OP_SCOND && b.op <= OP_READ) begin
            eng_kind  = b.op;
            eng_nack  = b.send_nack;
            eng_shift = (b.op == OP_WRITE) ? b.wdata : 8'h00;
            if (b.op == OP_READ) begin
               pin_oe  = 1'b0;
               pin_sda = 1'b1;
            end
            eng_phase = 5'd1;
            enter_pin_unit(UNIT_FIRST);
         end
      end else begin
         if (eng_count != '0) eng_count = eng_count - 1'b1;
         if (eng_count == '0) begin
            u = eng_phase - 5'd1;
            // sample on the last tick of the unit
            if (eng_kind == OP_READ && u < UNIT_BITS && !u[0])
               eng_shift = eng_shift | (8'(b.sda_in) << (3'd7 - u[3:1]));
            else if (eng_kind == OP_WRITE && u == UNIT_ACK1)
               eng_ack = b.sda_in;
            if (eng_kind == OP_WRITE)     n_units = UNIT_BITS + 5'd3;
            else if (eng_kind == OP_READ) n_units = UNIT_BITS + 5'd4;
            else                          n_units = 5'd5;
            if (u + 5'd1 >= n_units) begin
               if (eng_kind == OP_READ) eng_rdata = eng_shift;
               eng_phase = PHASE_IDLE;
               done = 1'b1;
            end else begin
               eng_phase = u + 5'd2;
               enter_pin_unit(u + 5'd1);
            end
         end
      end
      o.scl       = pin_scl;
      o.sda_level = pin_sda;
      o.sda_oe    = pin_oe;
      o.busy_res  = (eng_phase != PHASE_IDLE);
      o.done_res  = done;
      o.rdata     = eng_rdata;
      o.ack_seen  = eng_ack;
   endtask

   function automatic req_type mk_beat(input logic [OP_W-1:0] op, input logic [7:0] wdata,
                                       input logic nack, input logic sda);
      req_type b;
      b.op        = op;
      b.wdata     = wdata;
      b.send_nack = nack;
      b.sda_in    = sda;
      return b;
   endfunction

   // directed table builders
   function automatic void beat_row(input req_type b, input int unsigned reps);
      dir_rows.push_back('{kind: ROW_BEAT, beat: b, reps: reps, csr_value: '0,
                           typed: 1'b0, known: '0});
   endfunction

   function automatic void known_row(input req_type b, input rsp_type known);
      dir_rows.push_back('{kind: ROW_BEAT, beat: b, reps: 1, csr_value: '0,
                           typed: 1'b1, known: known});
   endfunction

   function automatic void csr_row(input logic [CFG_W-1:0] value);
      dir_rows.push_back('{kind: ROW_CSR, beat: '0, reps: 0, csr_value: value,
                           typed: 1'b0, known: '0});
   endfunction

   // offer one req beat, wait for acceptance, queue its expected rsp beat
   task automatic send_beat(input req_type b, input logic use_known, input rsp_type known);
      rsp_type predicted;
      if (!quiet && $urandom_range(0, 15) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= b.op;
      req_tdata  <= REQ_W'({b.sda_in, b.send_nack, b.wdata});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      advance_sequencer(b, predicted);
      predicted_rsp_q.push_back(use_known ? known : predicted);
      @(negedge clock);
   endtask

   // stop offering and wait until every expected rsp beat has come back
   task automatic drain_rsp();
      req_tvalid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(negedge clock);
   endtask

   // write delay_ticks with nothing in flight
   task automatic write_delay(input logic [CFG_W-1:0] value);
      drain_rsp();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      delay_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // rsp beat checker
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.scl       = rsp_tdata[0];
         got.sda_level = rsp_tdata[1];
         got.sda_oe    = rsp_tdata[2];
         got.busy_res  = rsp_tdata[3];
         got.done_res  = rsp_tdata[4];
         got.rdata     = rsp_tdata[12:5];
         got.ack_seen  = rsp_tdata[13];
         if (predicted_rsp_q.size() == 0) begin
            $error("rsp beat %h with nothing expected", rsp_tdata);
            fail_count++;
         end else begin
            want = predicted_rsp_q.pop_front();
            compare_field("scl", 8'(want.scl), 8'(got.scl));
            compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
            compare_field("sda_oe", 8'(want.sda_oe), 8'(got.sda_oe));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("rdata", want.rdata, got.rdata);
            compare_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
         end
      end
   end

   // receiver: random stall bursts, one long hold-off, none in the quiet part
   initial begin : rsp_side
      int unsigned held;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_go && !hold_done) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // sender: directed table, then random segments at several delays
   initial begin : stimulus
      stim_row_type     row;
      req_type          b;
      logic [OP_W-1:0]  pick_op;
      logic [CFG_W-1:0] seg_delay;
      int unsigned      dice;
      int               seg;
      int               n;
      int unsigned      k;

      eng_phase = PHASE_IDLE;
      eng_count = '0;
      eng_kind  = OP_NONE;
      eng_shift = 8'h00;
      eng_nack  = 1'b0;
      eng_ack   = 1'b0;
      eng_rdata = 8'h00;
      pin_scl   = PINS_RST.scl;
      pin_sda   = PINS_RST.sda;
      pin_oe    = PINS_RST.oe;
      delay_cfg = DELAY_RST;

      // idle after reset and the undefined op codes
      known_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), RSP_AT_RESET);
      known_row(mk_beat(OP_RSVD5, 8'hFF, 1'b1, 1'b1), RSP_AT_RESET);
      known_row(mk_beat(OP_RSVD6, 8'h00, 1'b0, 1'b0), RSP_AT_RESET);
      known_row(mk_beat(OP_RSVD7, 8'hFF, 1'b1, 1'b1), RSP_AT_RESET);
      // open condition at the reset delay; a stop while busy and a write on
      // the finishing tick are both dropped
      known_row(mk_beat(OP_SCOND, 8'h00, 1'b0, 1'b0), RSP_SCOND_ENTRY);
      beat_row(mk_beat(OP_PCOND, 8'h00, 1'b0, 1'b1), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 18);
      beat_row(mk_beat(OP_WRITE, 8'h3C, 1'b0, 1'b0), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 2);
      // zero delay runs as one tick per unit
      csr_row('0);
      beat_row(mk_beat(OP_WRITE, 8'hFF, 1'b0, 1'b0), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 20);
      beat_row(mk_beat(OP_WRITE, 8'h00, 1'b1, 1'b1), 1);
      beat_row(mk_beat(OP_NONE, 8'hFF, 1'b1, 1'b1), 20);
      beat_row(mk_beat(OP_READ, 8'h00, 1'b0, 1'b1), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b1), 21);
      beat_row(mk_beat(OP_READ, 8'hFF, 1'b1, 1'b0), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 21);
      beat_row(mk_beat(OP_PCOND, 8'h00, 1'b0, 1'b0), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 6);
      // long delay: cross a unit boundary, then shorten it mid command
      csr_row(16'd40);
      beat_row(mk_beat(OP_SCOND, 8'h00, 1'b0, 1'b1), 1);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b1), 60);
      csr_row(16'd3);
      beat_row(mk_beat(OP_NONE, 8'h00, 1'b0, 1'b0), 40);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            write_delay(row.csr_value);
         end else begin
            for (k = 0; k < row.reps; k++) send_beat(row.beat, row.typed, row.known);
         end
      end

      // random segments: mostly commands from idle with random content,
      // ticks with random sda, some dropped commands and undefined codes
      for (seg = 0; seg < SEG_COUNT; seg++) begin
         seg_delay = (seg == SEG_COUNT - 1) ? CFG_W'(1) : CFG_W'($urandom_range(0, 3));
         write_delay(seg_delay);
         if (seg == 1) hold_go = 1'b1;
         if (seg == SEG_COUNT - 1) quiet = 1'b1;
         for (n = 0; n < SEG_BEATS; n++) begin
            dice = $urandom_range(0, 99);
            if (eng_phase == PHASE_IDLE) begin
               if (dice < 75)      pick_op = OP_W'($urandom_range(OP_SCOND, OP_READ));
               else if (dice < 85) pick_op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
               else                pick_op = OP_NONE;
            end else begin
               pick_op = (dice < 12) ? OP_W'($urandom_range(OP_SCOND, OP_RSVD7)) : OP_NONE;
            end
            b = mk_beat(pick_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            send_beat(b, 1'b0, '0);
         end
      end

      // wait out the pipeline, then report
      drain_rsp();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS i2c_master_bit_engine_core");
      end else begin
         $display("FAIL i2c_master_bit_engine_core");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(20_000_000);
      $display("FAIL i2c_master_bit_engine_core");
      $finish;
   end

endmodule

`default_nettype wire
